>>> hw/rtl/nfcfb_pkg.sv
// ----------------------------------------------------------------------------
// nfcfb_pkg
// Shared types and constants for the command frame builder: beat payloads,
// the per-item frame descriptor and the output sequencer steps.
// ----------------------------------------------------------------------------
package nfcfb_pkg;

    // fixed frame bytes and the payload limit
    localparam logic [7:0] LEAD_ZERO   = 8'h00;
    localparam logic [7:0] LEAD_START  = 8'hFF;
    localparam logic [7:0] POSTAMBLE   = 8'h00;
    localparam logic [7:0] ID_RESET    = 8'hD4;
    localparam logic [7:0] MAX_PAYLOAD = 8'd254;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic [7:0] payload_count;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out_beat;

    // everything the sequencer needs to emit the bytes of one input item
    typedef struct packed {
        logic       header;     // frame opens with this byte
        logic       trailer;    // frame closes after this byte
        logic [7:0] len;
        logic [7:0] len_csum;
        logic [7:0] ident;
        logic [7:0] data;
        logic [7:0] data_csum;
    } t_frame_desc;

    // output sequencer steps
    typedef enum logic [3:0] {
        STEP_LEAD0,
        STEP_LEAD1,
        STEP_START,
        STEP_LEN,
        STEP_LCS,
        STEP_ID,
        STEP_DATA,
        STEP_DCS,
        STEP_POST
    } t_step;

endpackage

>>> hw/rtl/nfc_command_frame_builder.sv
// The first output beat of an item is valid in the cycle after the item is accepted.
// Throughput: one input beat per cycle while each item yields at most one byte and the
// output is ready; an item that opens a frame emits 7 or 9 bytes, one byte per cycle while
// the output is ready, and a closing item emits 3 bytes.
// Reset: synchronous, active low; frame state clears, identifier returns to 0xD4,
// output queue empties.
// ----------------------------------------------------------------------------
// nfc_command_frame_builder
// Wraps payload bytes into host-to-controller information frames with lead-in,
// length, length checksum, identifier, data checksum and postamble.
// ----------------------------------------------------------------------------
module nfc_command_frame_builder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  nfcfb_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output nfcfb_pkg::t_out_beat o_out_beat
);

    nfcfb_pkg::t_frame_desc desc;
    logic                   desc_valid;
    logic                   can_load;
    logic                   accept;

    // input handshake
    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    // frame tracking
    nfcfb_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_beat        (i_in_beat),
        .o_desc_valid  (desc_valid),
        .o_desc        (desc)
    );

    // byte output
    nfcfb_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && desc_valid),
        .i_desc      (desc),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

>>> hw/rtl/nfcfb_framer.sv
// ----------------------------------------------------------------------------
// nfcfb_framer
// Frame tracking: identifier register, remaining byte count and running
// checksum sum; builds the descriptor of bytes caused by one input beat.
// ----------------------------------------------------------------------------
module nfcfb_framer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic                  i_accept,
    input  nfcfb_pkg::t_in_beat   i_beat,
    output logic                  o_desc_valid,
    output nfcfb_pkg::t_frame_desc o_desc
);

    logic [7:0] r_ident;
    logic [7:0] r_remaining;
    logic [7:0] r_sum;

    logic [7:0] cnt;
    logic [7:0] len;
    logic [7:0] sum0;
    logic [7:0] sum1;
    logic [7:0] rem0;
    logic [7:0] rem1;
    logic       active;
    logic       tail;

    // clamp the count and pick the starting state for this beat
    always_comb begin
        if (i_beat.payload_count == 8'd0) begin
            cnt = 8'd1;
        end else if (i_beat.payload_count > nfcfb_pkg::MAX_PAYLOAD) begin
            cnt = nfcfb_pkg::MAX_PAYLOAD;
        end else begin
            cnt = i_beat.payload_count;
        end
        len = cnt + 8'd1;
        if (i_beat.first_byte) begin
            sum0 = r_ident;
            rem0 = cnt;
        end else begin
            sum0 = r_sum;
            rem0 = r_remaining;
        end
        active = i_beat.first_byte || (r_remaining != 8'd0);
        sum1   = sum0 + i_beat.data_byte;
        rem1   = rem0 - 8'd1;
        tail   = (rem1 == 8'd0);
    end

    // descriptor of the bytes to emit
    always_comb begin
        o_desc_valid       = active;
        o_desc.header      = i_beat.first_byte;
        o_desc.trailer     = tail;
        o_desc.len         = len;
        o_desc.len_csum    = 8'd0 - len;
        o_desc.ident       = r_ident;
        o_desc.data        = i_beat.data_byte;
        o_desc.data_csum   = 8'd0 - sum1;
    end

    // identifier register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident <= nfcfb_pkg::ID_RESET;
        end else if (i_cfg_wr_en) begin
            r_ident <= i_cfg_wr_data;
        end
    end

    // frame progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 8'd0;
            r_sum       <= 8'd0;
        end else if (i_accept && active) begin
            r_remaining <= rem1;
            r_sum       <= tail ? 8'd0 : sum1;
        end
    end

endmodule

>>> hw/rtl/nfcfb_serializer.sv
// ----------------------------------------------------------------------------
// nfcfb_serializer
// Holds one frame descriptor and sends its bytes out one beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
module nfcfb_serializer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  nfcfb_pkg::t_frame_desc i_desc,
    output logic                   o_can_load,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output nfcfb_pkg::t_out_beat   o_out_beat
);

    nfcfb_pkg::t_frame_desc r_desc;
    nfcfb_pkg::t_step       r_step;
    nfcfb_pkg::t_step       n_step;
    logic                   r_busy;
    logic                   n_busy;
    logic                   last;

    // step sequencing and output byte select
    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        last   = 1'b0;
        o_out_beat.frame_end = 1'b0;
        unique case (r_step)
            nfcfb_pkg::STEP_LEAD0: begin
                o_out_beat.frame_byte = nfcfb_pkg::LEAD_ZERO;
                n_step = nfcfb_pkg::STEP_LEAD1;
            end
            nfcfb_pkg::STEP_LEAD1: begin
                o_out_beat.frame_byte = nfcfb_pkg::LEAD_ZERO;
                n_step = nfcfb_pkg::STEP_START;
            end
            nfcfb_pkg::STEP_START: begin
                o_out_beat.frame_byte = nfcfb_pkg::LEAD_START;
                n_step = nfcfb_pkg::STEP_LEN;
            end
            nfcfb_pkg::STEP_LEN: begin
                o_out_beat.frame_byte = r_desc.len;
                n_step = nfcfb_pkg::STEP_LCS;
            end
            nfcfb_pkg::STEP_LCS: begin
                o_out_beat.frame_byte = r_desc.len_csum;
                n_step = nfcfb_pkg::STEP_ID;
            end
            nfcfb_pkg::STEP_ID: begin
                o_out_beat.frame_byte = r_desc.ident;
                n_step = nfcfb_pkg::STEP_DATA;
            end
            nfcfb_pkg::STEP_DATA: begin
                o_out_beat.frame_byte = r_desc.data;
                n_step = nfcfb_pkg::STEP_DCS;
                last   = !r_desc.trailer;
            end
            nfcfb_pkg::STEP_DCS: begin
                o_out_beat.frame_byte = r_desc.data_csum;
                n_step = nfcfb_pkg::STEP_POST;
            end
            nfcfb_pkg::STEP_POST: begin
                o_out_beat.frame_byte = nfcfb_pkg::POSTAMBLE;
                o_out_beat.frame_end  = 1'b1;
                last   = 1'b1;
            end
            default: begin
                o_out_beat.frame_byte = nfcfb_pkg::POSTAMBLE;
                last   = 1'b1;
            end
        endcase

        // a new descriptor may enter when empty or when the last beat leaves
        o_can_load  = !r_busy || (i_out_ready && last);
        o_out_valid = r_busy;

        if (i_load) begin
            n_busy = 1'b1;
            n_step = i_desc.header ? nfcfb_pkg::STEP_LEAD0 : nfcfb_pkg::STEP_DATA;
        end else if (r_busy && i_out_ready && last) begin
            n_busy = 1'b0;
        end else if (!(r_busy && i_out_ready)) begin
            n_step = r_step;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= nfcfb_pkg::STEP_DATA;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    // descriptor register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
    end

endmodule
